### rtl/float_to_linear11_encoder_defines.svh
// Assertion macros shared by the encoder RTL
`ifndef FLOAT_TO_LINEAR11_ENCODER_DEFINES_SVH
`define FLOAT_TO_LINEAR11_ENCODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define F2L_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("f2l assertion failed");
`define F2L_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("f2l assertion failed");
`else
`define F2L_ASSERT(label, clk, rst_n, prop)
`define F2L_ASSERT_NORST(label, clk, prop)
`endif
`endif

### rtl/f2l_pkg.sv
package f2l_pkg;
    localparam int VALUE_W  = 32;
    localparam int WORD_W   = 16;
    localparam int MANT_W   = 11;
    localparam int EXPN_W   = 5;
    localparam int STAGES   = 3;
    localparam logic [7:0]  BEXP_SPECIAL = 8'hFF;
    localparam logic [7:0]  BEXP_ZERO    = 8'h00;
    localparam logic signed [9:0] EXP_MIN = -10'sd16;
    localparam logic signed [9:0] EXP_MAX = 10'sd15;
    localparam logic [10:0] MANT_POS_SAT = 11'h3FF;
    localparam logic [10:0] MANT_NEG_SAT = 11'h400;
    localparam logic [15:0] WORD_NAN     = 16'h0000;

    typedef enum logic [1:0] {
        K_NORMAL = 2'd0,
        K_ZERO   = 2'd1,
        K_SAT    = 2'd2,
        K_NAN    = 2'd3
    } t_kind;
endpackage

### rtl/f2l_stream_if.sv
interface f2l_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/f2l_out_if.sv
interface f2l_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] linear_word;
    logic        range_flag;
    modport source (output valid, output linear_word, output range_flag, input ready);
    modport sink   (input valid, input linear_word, input range_flag, output ready);
endinterface

### rtl/float_to_linear11_encoder.sv
// channel  | dir | payload
// i_in     | in  | data[31:0] = value_bits (IEEE-754 single)
// o_out    | out | linear_word[15:0], range_flag
// One item per cycle unless o_out stalls; three register stages: classify/exponent, shift, pack.
// An input beat goes through the classify/exponent, shift and pack registers
// in that order before it shows on o_out.
// i_rst_n is synchronous, active low, and clears the stage valid bits.
// A stall at the output holds every stage; i_in.ready = !o_out.valid || o_out.ready.
`include "float_to_linear11_encoder_defines.svh"
module float_to_linear11_encoder (
    input  logic i_clk,
    input  logic i_rst_n,
    f2l_stream_if.sink i_in,
    f2l_out_if.source  o_out
);
    import f2l_pkg::*;

    logic        w_adv;
    assign w_adv = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 1: classify and choose exponent
    logic        r1_v, r2_v, r3_v;
    t_kind       r1_kind, n1_kind;
    logic        r1_neg;
    logic [23:0] r1_sig;
    logic signed [9:0] r1_n, n1_n, r1_sh, n1_sh;
    logic [7:0]  w_bexp;
    logic [22:0] w_frac;
    logic [23:0] w_sig;
    logic signed [9:0] w_e2;
    logic [4:0]  w_msb;
    logic signed [9:0] w_top;

    assign w_bexp = i_in.data[30:23];
    assign w_frac = i_in.data[22:0];
    assign w_sig  = (w_bexp == BEXP_ZERO) ? {1'b0, w_frac} : {1'b1, w_frac};
    assign w_e2   = (w_bexp == BEXP_ZERO) ? -10'sd149
                                          : $signed({2'b00, w_bexp}) - 10'sd150;

    always_comb begin
        w_msb = 5'd0;
        for (int k = 0; k < 24; k++) begin
            if (w_sig[k]) w_msb = k[4:0];
        end
    end

    // value ~ sig*2^e2; top bit weight e2+msb. Need mag>>n <= 1023 (or 1024 neg):
    // smallest n with e2+msb-n <= 9, i.e. n = e2+msb-9. A negative value fits one
    // step lower when the ten bits below its top bit are zero (truncates to 1024).
    logic [23:0] w_norm;
    logic w_q1024;
    assign w_norm  = w_sig << (5'd23 - w_msb);
    assign w_q1024 = (w_norm[22:13] == 10'd0);
    assign w_top  = w_e2 + $signed({5'd0, w_msb}) - 10'sd9
                    - ((i_in.data[31] && w_q1024) ? 10'sd1 : 10'sd0);

    always_comb begin
        n1_kind = K_NORMAL;
        n1_n    = w_top;
        if (w_bexp == BEXP_SPECIAL) begin
            n1_kind = (w_frac != 23'd0) ? K_NAN : K_SAT;
            n1_n    = EXP_MAX;
        end else if (w_sig == 24'd0) begin
            n1_kind = K_ZERO;
            n1_n    = EXP_MIN;
        end else if (w_top < EXP_MIN) begin
            n1_n = EXP_MIN;
        end else if (w_top > EXP_MAX) begin
            n1_kind = K_SAT;
            n1_n    = EXP_MAX;
        end
        n1_sh = w_e2 - n1_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= i_in.valid;
        end
        if (w_adv) begin
            r1_kind <= n1_kind;
            r1_neg  <= i_in.data[31];
            r1_sig  <= w_sig;
            r1_n    <= n1_n;
            r1_sh   <= n1_sh;
        end
    end

    // stage 2: shift magnitude
    logic [10:0] n2_mag, r2_mag;
    t_kind       r2_kind;
    logic        r2_neg;
    logic [4:0]  r2_n;
    logic [6:0]  w_rs;
    logic [34:0] w_shl;

    assign w_rs  = (-r1_sh > 10'sd63) ? 7'd63 : 7'(-r1_sh);
    assign w_shl = {11'd0, r1_sig} << r1_sh[3:0];

    always_comb begin
        if (r1_sh >= 0) n2_mag = w_shl[10:0];
        else            n2_mag = 11'({40'd0, r1_sig} >> w_rs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= r1_v;
        end
        if (w_adv) begin
            r2_mag  <= n2_mag;
            r2_kind <= r1_kind;
            r2_neg  <= r1_neg;
            r2_n    <= r1_n[4:0];
        end
    end

    // stage 3: pack
    logic [15:0] n3_word;
    logic        n3_flag;
    logic [10:0] w_y;
    always_comb begin
        w_y = r2_neg ? (11'd0 - r2_mag) : r2_mag;
        case (r2_kind)
            K_NAN: begin
                n3_word = WORD_NAN;
                n3_flag = 1'b1;
            end
            K_SAT: begin
                n3_word = {r2_n, r2_neg ? MANT_NEG_SAT : MANT_POS_SAT};
                n3_flag = 1'b1;
            end
            K_ZERO: begin
                n3_word = {r2_n, 11'd0};
                n3_flag = 1'b0;
            end
            default: begin
                n3_word = {r2_n, w_y};
                n3_flag = 1'b0;
            end
        endcase
    end

    logic [15:0] r3_word;
    logic        r3_flag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_adv) begin
            r3_v <= r2_v;
        end
        if (w_adv) begin
            r3_word <= n3_word;
            r3_flag <= n3_flag;
        end
    end

    assign o_out.valid       = r3_v;
    assign o_out.linear_word = r3_word;
    assign o_out.range_flag  = r3_flag;

    `F2L_ASSERT(a_hold_stall, i_clk, i_rst_n, (o_out.valid && !o_out.ready) |=> $stable(r3_word))
    `F2L_ASSERT(a_nan_zero, i_clk, i_rst_n, (r2_kind == K_NAN && w_adv) |=> (r3_word == WORD_NAN))
    `F2L_ASSERT(a_adv_move, i_clk, i_rst_n, (w_adv && r2_v) |=> r3_v)
    `F2L_ASSERT_NORST(a_rst_clear, i_clk, !i_rst_n |=> !o_out.valid)
endmodule
